// ===== rtl/sebp_pkg.sv =====
// Shared types and constants for the bit-serial EEPROM block.
// Used by serial_eeprom_bit_protocol; has no dependencies of its own.
package sebp_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int PTR_W = 13;
  localparam int SHIFT_W = 14;
  localparam int COUNT_W = 7;
  localparam int BLOCK_KEEP_W = 10;

  localparam int ADDR_BITS_SMALL = 6;
  localparam int ADDR_BITS_LARGE = 14;
  localparam int REQ_BITS = 2;
  localparam int DATA_BITS = 64;
  localparam int WRITE_STOP_COUNT = 65;
  localparam int COUNTDOWN_RESET = 68;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;
  localparam logic IDLE_BIT = 1'b1;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_OTHER = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_COMMAND = 2'd0,
    PH_ADDRESS = 2'd1,
    PH_DATA    = 2'd2
  } phase_t;

endpackage

// ===== rtl/serial_eeprom_bit_protocol.sv =====
// Bit-serial EEPROM: protocol sequencer, byte memory and result pipeline.
// Depends on sebp_pkg for constants and the phase and request types.
//
// Usage: each beat on the slave side is one bus access. s_tuser is the
// access kind (0 = write access carrying s_tdata bit 0, 1 = read access).
// Every read access yields exactly one beat on the master side with the
// returned bit in m_tdata bit 0; write accesses yield nothing.
// Throughput is one access per cycle while s_tready is high. A read result
// is registered first by the synchronous byte memory read and then by the
// output register.
// A stage between the memory and the output register lets one more read
// be accepted while a result waits; beyond that s_tready drops until the
// receiver takes the waiting beat, and nothing is lost or repeated.
// After reset the block runs a clearing pass that fills every byte with
// 0xFF; s_tready stays low during that pass. The size register (cfg_wr_en,
// cfg_wr_data) is written at any clock edge with the enable high, and
// should only change while the block is idle.
module serial_eeprom_bit_protocol
  import sebp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] bit_in, [7:1] zero
  input  logic       s_tuser,   // [0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] read_bit, [7:1] zero
);

  logic large_part;

  phase_t phase, phase_next;
  req_t pending_request, pending_request_next;
  logic [SHIFT_W-1:0] shift_bits, shift_bits_next;
  logic [COUNT_W-1:0] bit_count, bit_count_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [COUNT_W-1:0] read_countdown, read_countdown_next;

  logic clearing;
  logic [MEM_AW-1:0] clear_addr;

  logic [7:0] cells [MEM_BYTES];
  logic [7:0] rd_data;
  logic mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic mem_re;
  logic store_byte;

  logic s2_valid;
  logic s2_is_data;
  logic [2:0] s2_pos;
  logic out_bit;

  logic out_free, s2_move, s2_free;
  logic accept, rd_acc, wr_acc;
  logic [SHIFT_W-1:0] sb_shifted;
  logic [COUNT_W-1:0] bc_inc;
  logic [COUNT_W-1:0] cd_dec;
  logic [COUNT_W-1:0] addr_width;
  logic rd_is_data;

  assign out_free = !m_tvalid || m_tready;
  assign s2_move = s2_valid && out_free;
  assign s2_free = !s2_valid || out_free;
  assign s_tready = !clearing && s2_free;
  assign accept = s_tvalid && s_tready;
  assign rd_acc = accept && s_tuser;
  assign wr_acc = accept && !s_tuser;

  assign sb_shifted = {shift_bits[SHIFT_W-2:0], s_tdata[0]};
  assign bc_inc = bit_count + COUNT_W'(1);
  assign cd_dec = read_countdown - COUNT_W'(1);
  assign addr_width = large_part ? COUNT_W'(ADDR_BITS_LARGE) : COUNT_W'(ADDR_BITS_SMALL);
  assign rd_is_data = (pending_request == REQ_READ) && (cd_dec < COUNT_W'(DATA_BITS));

  always_comb begin
    phase_next = phase;
    pending_request_next = pending_request;
    shift_bits_next = shift_bits;
    bit_count_next = bit_count;
    read_pointer_next = read_pointer;
    write_pointer_next = write_pointer;
    read_countdown_next = read_countdown;
    store_byte = 1'b0;
    mem_re = 1'b0;

    if (wr_acc) begin
      shift_bits_next = sb_shifted;
      bit_count_next = bc_inc;
      case (phase)
        PH_ADDRESS: begin
          if (bc_inc == addr_width) begin
            if (pending_request == REQ_READ) begin
              read_pointer_next = {sb_shifted[BLOCK_KEEP_W-1:0], 3'b000};
            end else if (pending_request == REQ_WRITE) begin
              write_pointer_next = {sb_shifted[BLOCK_KEEP_W-1:0], 3'b000};
            end
            phase_next = PH_DATA;
            shift_bits_next = '0;
            bit_count_next = '0;
          end
        end
        PH_DATA: begin
          if (pending_request == REQ_READ || bc_inc == COUNT_W'(WRITE_STOP_COUNT)) begin
            phase_next = PH_COMMAND;
            shift_bits_next = '0;
            bit_count_next = '0;
          end else if (bc_inc[2:0] == 3'd0) begin
            store_byte = 1'b1;
            write_pointer_next = write_pointer + PTR_W'(1);
            shift_bits_next = '0;
          end
        end
        default: begin
          if (bc_inc == COUNT_W'(REQ_BITS)) begin
            pending_request_next = req_t'(sb_shifted[1:0]);
            phase_next = PH_ADDRESS;
            shift_bits_next = '0;
            bit_count_next = '0;
          end
        end
      endcase
    end else if (rd_acc && pending_request == REQ_READ) begin
      read_countdown_next = cd_dec;
      if (rd_is_data) begin
        mem_re = 1'b1;
        if (cd_dec[2:0] == 3'd0) begin
          read_pointer_next = read_pointer + PTR_W'(1);
        end
        if (cd_dec == '0) begin
          read_countdown_next = COUNT_W'(COUNTDOWN_RESET);
        end
      end
    end
  end

  assign mem_we = clearing || store_byte;
  assign mem_waddr = clearing ? clear_addr : write_pointer[MEM_AW-1:0];
  assign mem_wdata = clearing ? ERASED_BYTE : sb_shifted[7:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= cells[read_pointer[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      large_part <= 1'b0;
      phase <= PH_COMMAND;
      pending_request <= REQ_NONE;
      shift_bits <= '0;
      bit_count <= '0;
      read_pointer <= '0;
      write_pointer <= '0;
      read_countdown <= COUNT_W'(COUNTDOWN_RESET);
      clearing <= 1'b1;
      clear_addr <= '0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        large_part <= cfg_wr_data;
      end
      phase <= phase_next;
      pending_request <= pending_request_next;
      shift_bits <= shift_bits_next;
      bit_count <= bit_count_next;
      read_pointer <= read_pointer_next;
      write_pointer <= write_pointer_next;
      read_countdown <= read_countdown_next;
      if (clearing) begin
        clear_addr <= clear_addr + MEM_AW'(1);
        if (clear_addr == MEM_AW'(MEM_BYTES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (rd_acc) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      s2_is_data <= rd_is_data;
      s2_pos <= cd_dec[2:0];
    end
    if (s2_move) begin
      out_bit <= s2_is_data ? rd_data[s2_pos] : IDLE_BIT;
    end
  end

  assign m_tdata = {7'b0, out_bit};

`ifndef ASSERT_OFF
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("access accepted during clearing pass");

  a_data_read_needs_read_request: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (pending_request == REQ_READ) && !clearing)
    else $error("memory read issued without a pending read request");

  a_countdown_range: assert property (@(posedge clk) disable iff (rst)
    (read_countdown != '0) && (read_countdown <= COUNT_W'(COUNTDOWN_RESET)))
    else $error("read countdown out of range");

  a_data_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bit_count <= COUNT_W'(DATA_BITS)))
    else $error("data phase bit count out of range");

  a_result_follows_read: assert property (@(posedge clk) disable iff (rst)
    rd_acc |=> s2_valid)
    else $error("read access did not produce a pending result");
`endif

endmodule
